// ===== rtl/ndtl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ndtl_pkg
// Shared widths, opcodes and status codes of the nearest-depth table lookup.
// ----------------------------------------------------------------------------
package ndtl_pkg;

  localparam int OPCODE_W    = 2;
  localparam int DEPTH_W     = 24;
  localparam int WORD_W      = 64;
  localparam int INDEX_W     = 6;
  localparam int STATUS_W    = 2;

  localparam int IN_TDATA_W  = DEPTH_W + WORD_W;                         // 88
  localparam int OUT_TDATA_W = ((WORD_W + INDEX_W + 7) / 8) * 8;         // 72
  localparam int OUT_TUSER_W = STATUS_W + 1;

  localparam int unsigned TABLE_DEPTH_DEF  = 64;
  localparam int unsigned DISTANCE_CAP_DEF = 10000000;

  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

endpackage
`default_nettype wire

// ===== rtl/ndtl_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ndtl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ndtl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/nearest_depth_table_lookup.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_depth_table_lookup
// Depth-keyed table: clear, append and nearest-depth query with one
// distance comparator scanning the key RAM one entry per cycle.
// Flow: clear/append go from IDLE to DONE; a query passes IDLE, SCAN, WORD
// (skipped when no entry matches) and DONE; DONE holds while out_tvalid waits.
// Throughput: one request at a time; a query occupies the block for the
// whole key scan, set by the single key RAM read port and comparator.
// Reset: synchronous, table empty, min/max bounds at their empty values;
// RAM contents are not cleared.
// ----------------------------------------------------------------------------
module nearest_depth_table_lookup #(
  parameter int unsigned TABLE_DEPTH  = ndtl_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned DISTANCE_CAP = ndtl_pkg::DISTANCE_CAP_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  input  wire  [ndtl_pkg::IN_TDATA_W-1:0] in_tdata,   // depth_m[23:0], entry_word[87:24]
  input  wire  [ndtl_pkg::OPCODE_W-1:0]   in_tuser,   // opcode[1:0]
  output logic                            out_tvalid,
  input  wire                             out_tready,
  output logic [ndtl_pkg::OUT_TDATA_W-1:0] out_tdata, // found_word[63:0], found_index[69:64]
  output logic [ndtl_pkg::OUT_TUSER_W-1:0] out_tuser  // status[1:0], out_of_range[2]
);
  import ndtl_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0]   FULL_CNT = CNT_W'(TABLE_DEPTH);
  localparam logic [DEPTH_W-1:0] CAP      = DEPTH_W'(DISTANCE_CAP);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_WORD = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [DEPTH_W-1:0]     least_r, least_nxt;
  logic [DEPTH_W-1:0]     greatest_r, greatest_nxt;
  logic [DEPTH_W-1:0]     qdepth_r, qdepth_nxt;
  logic [CNT_W-1:0]       scan_r, scan_nxt;
  logic                   cmp_v_r, cmp_v_nxt;
  logic [IDX_W-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic [DEPTH_W-1:0]     best_r, best_nxt;
  logic [IDX_W-1:0]       pick_r, pick_nxt;
  logic                   hit_r, hit_nxt;
  logic [WORD_W-1:0]      res_word_r, res_word_nxt;
  logic [INDEX_W-1:0]     res_idx_r, res_idx_nxt;
  logic [STATUS_W-1:0]    res_status_r, res_status_nxt;
  logic                   res_oor_r, res_oor_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic [OUT_TUSER_W-1:0] out_user_r, out_user_nxt;

  logic [OPCODE_W-1:0]    in_opcode;
  logic [DEPTH_W-1:0]     in_depth;
  logic [WORD_W-1:0]      in_word;
  logic                   wr_en;
  logic [DEPTH_W-1:0]     key_rdata;
  logic [WORD_W-1:0]      word_rdata;
  logic                   issue;
  logic [DEPTH_W-1:0]     key_gap;
  logic [IDX_W+INDEX_W-1:0] pick_ext;

  assign in_opcode = in_tuser;
  assign in_depth  = in_tdata[DEPTH_W-1:0];
  assign in_word   = in_tdata[IN_TDATA_W-1:DEPTH_W];

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  ndtl_ram #(.WIDTH(DEPTH_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (in_depth),
    .raddr (scan_r[IDX_W-1:0]),
    .rdata (key_rdata)
  );

  ndtl_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_DEPTH)) u_word_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (in_word),
    .raddr (pick_r),
    .rdata (word_rdata)
  );

  assign issue    = (scan_r < count_r);
  assign key_gap  = (key_rdata >= qdepth_r) ? (key_rdata - qdepth_r) : (qdepth_r - key_rdata);
  assign pick_ext = {{INDEX_W{1'b0}}, pick_r};

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    least_nxt      = least_r;
    greatest_nxt   = greatest_r;
    qdepth_nxt     = qdepth_r;
    scan_nxt       = scan_r;
    cmp_v_nxt      = cmp_v_r;
    cmp_idx_nxt    = cmp_idx_r;
    best_nxt       = best_r;
    pick_nxt       = pick_r;
    hit_nxt        = hit_r;
    res_word_nxt   = res_word_r;
    res_idx_nxt    = res_idx_r;
    res_status_nxt = res_status_r;
    res_oor_nxt    = res_oor_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    wr_en          = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          res_word_nxt   = '0;
          res_idx_nxt    = '0;
          res_status_nxt = ST_OK;
          res_oor_nxt    = 1'b0;
          state_nxt      = S_DONE;
          case (in_opcode)
            OP_CLEAR: begin
              count_nxt    = '0;
              least_nxt    = '1;
              greatest_nxt = '0;
            end
            OP_APPEND: begin
              if (count_r == FULL_CNT) begin
                res_status_nxt = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + 1'b1;
                if (in_depth < least_r) begin
                  least_nxt = in_depth;
                end
                if (in_depth > greatest_r) begin
                  greatest_nxt = in_depth;
                end
              end
            end
            OP_QUERY: begin
              qdepth_nxt  = in_depth;
              scan_nxt    = '0;
              cmp_v_nxt   = 1'b0;
              best_nxt    = CAP;
              pick_nxt    = '0;
              hit_nxt     = 1'b0;
              res_oor_nxt = (in_depth < least_r) || (in_depth > greatest_r);
              state_nxt   = S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        cmp_v_nxt   = issue;
        cmp_idx_nxt = scan_r[IDX_W-1:0];
        if (issue) begin
          scan_nxt = scan_r + 1'b1;
        end
        // ties go to the later entry
        if (cmp_v_r && (key_gap <= best_r)) begin
          best_nxt = key_gap;
          pick_nxt = cmp_idx_r;
          hit_nxt  = 1'b1;
        end
        if (!issue && !cmp_v_r) begin
          if (hit_r) begin
            state_nxt = S_WORD;
          end else begin
            res_status_nxt = ST_MISS;
            state_nxt      = S_DONE;
          end
        end
      end
      S_WORD: begin
        res_word_nxt = word_rdata;
        res_idx_nxt  = pick_ext[INDEX_W-1:0];
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_TDATA_W'({res_idx_r, res_word_r});
          out_user_nxt  = {res_oor_r, res_status_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      least_r     <= '1;
      greatest_r  <= '0;
      cmp_v_r     <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      least_r     <= least_nxt;
      greatest_r  <= greatest_nxt;
      cmp_v_r     <= cmp_v_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    qdepth_r     <= qdepth_nxt;
    scan_r       <= scan_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    best_r       <= best_nxt;
    pick_r       <= pick_nxt;
    res_word_r   <= res_word_nxt;
    res_idx_r    <= res_idx_nxt;
    res_status_r <= res_status_nxt;
    res_oor_r    <= res_oor_nxt;
    out_data_r   <= out_data_nxt;
    out_user_r   <= out_user_nxt;
  end

endmodule
`default_nettype wire
